@@ sv/sfva_pkg.sv @@
package sfva_pkg;

    typedef enum logic [2:0] {
        OP_ADD    = 3'd0,
        OP_SUB    = 3'd1,
        OP_MUL    = 3'd2,
        OP_DIV    = 3'd3,
        OP_RELU   = 3'd4,
        OP_CLAMP6 = 3'd5
    } t_op;

    typedef struct packed {
        logic valid;
        logic last;
        logic is_div;
        logic neg;
        logic zero;
    } t_ctl;

endpackage

@@ sv/sfva_div_cell.sv @@
module sfva_div_cell #(
    parameter int DATA_WIDTH = 16,
    parameter int WORD_BITS  = 24
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  sfva_pkg::t_ctl          i_ctl,
    input  logic [DATA_WIDTH-1:0]   i_side,
    input  logic [DATA_WIDTH-1:0]   i_den,
    input  logic [DATA_WIDTH-1:0]   i_rem,
    input  logic [WORD_BITS-1:0]    i_word,
    output sfva_pkg::t_ctl          o_ctl,
    output logic [DATA_WIDTH-1:0]   o_side,
    output logic [DATA_WIDTH-1:0]   o_den,
    output logic [DATA_WIDTH-1:0]   o_rem,
    output logic [WORD_BITS-1:0]    o_word
);
    import sfva_pkg::*;

    t_ctl                  r_ctl;
    logic [DATA_WIDTH-1:0] r_side;
    logic [DATA_WIDTH-1:0] r_den;
    logic [DATA_WIDTH-1:0] r_rem;
    logic [WORD_BITS-1:0]  r_word;
    logic [DATA_WIDTH-1:0] n_rem;
    logic [WORD_BITS-1:0]  n_word;
    logic [DATA_WIDTH-1:0] shifted;
    logic                  ge;

    always_comb begin
        shifted = {i_rem[DATA_WIDTH-2:0], i_word[WORD_BITS-1]};
        ge      = shifted >= i_den;
        n_rem   = ge ? (shifted - i_den) : shifted;
        n_word  = {i_word[WORD_BITS-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= i_ctl;
        end
        r_side <= i_side;
        r_den  <= i_den;
        r_rem  <= n_rem;
        r_word <= n_word;
    end

    assign o_ctl  = r_ctl;
    assign o_side = r_side;
    assign o_den  = r_den;
    assign o_rem  = r_rem;
    assign o_word = r_word;

endmodule

@@ sv/saturating_fixed_point_vector_alu.sv @@
// Saturating fixed-point ALU: one item per cycle, busy is never raised and the
// receiver cannot stall. Each item passes the input registers, the first-stage
// result registers, a chain of divider cells, one per quotient bit, and the output
// register; every operation travels through the chain to keep items in order.
// The operation is latched with each item; write it only while the block is idle.
module saturating_fixed_point_vector_alu #(
    parameter int DATA_WIDTH = 16,
    parameter int INT_BITS   = 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic signed [DATA_WIDTH-1:0] i_a_value,
    input  logic signed [DATA_WIDTH-1:0] i_b_value,
    input  logic                         i_last_in,
    output logic                         o_valid,
    output logic signed [DATA_WIDTH-1:0] o_result_value,
    output logic                         o_last_out,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [2:0]                   i_cfg_data
);
    import sfva_pkg::*;

    localparam int W    = DATA_WIDTH;
    localparam int FRAC = DATA_WIDTH - INT_BITS;
    localparam int NB   = DATA_WIDTH + FRAC;
    localparam logic [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};
    localparam logic [W-1:0] SIX  = W'(6 << FRAC);

    t_op                    r_op;
    logic                   r0_valid;
    logic                   r0_last;
    t_op                    r0_op;
    logic signed [W-1:0]    r0_a;
    logic signed [W-1:0]    r0_b;
    logic signed [2*W-1:0]  r0_prod;

    t_ctl                   n1_ctl;
    logic [W-1:0]           n1_side;
    logic [W-1:0]           n1_den;
    logic [NB-1:0]          n1_word;
    logic [W:0]             sum;
    logic [W:0]             diff;
    logic signed [2*W-1:0]  prod_sh;
    logic [W-1:0]           amag;

    t_ctl                   s_ctl  [0:NB];
    logic [W-1:0]           s_side [0:NB];
    logic [W-1:0]           s_den  [0:NB];
    logic [W-1:0]           s_rem  [0:NB];
    logic [NB-1:0]          s_word [0:NB];

    t_ctl                   r1_ctl;
    logic [W-1:0]           r1_side;
    logic [W-1:0]           r1_den;
    logic [NB-1:0]          r1_word;

    logic [NB+1:0]          sq;
    logic                   fits;
    logic [W-1:0]           div_res;
    logic                   r_valid;
    logic [W-1:0]           r_res;
    logic                   r_last;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op     <= OP_ADD;
            r0_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_op <= t_op'(i_cfg_data);
            end
            r0_valid <= start;
        end
        r0_last <= i_last_in;
        r0_op   <= r_op;
        r0_a    <= i_a_value;
        r0_b    <= i_b_value;
        r0_prod <= i_a_value * i_b_value;
    end

    always_comb begin
        sum     = {r0_a[W-1], r0_a} + {r0_b[W-1], r0_b};
        diff    = {r0_a[W-1], r0_a} - {r0_b[W-1], r0_b};
        prod_sh = r0_prod >>> FRAC;
        amag    = r0_a[W-1] ? (~r0_a + 1'b1) : r0_a;
        n1_den  = r0_b[W-1] ? (~r0_b + 1'b1) : r0_b;
        n1_word = {amag, {FRAC{1'b0}}};
        unique case (r0_op)
            OP_ADD: begin
                n1_side = (sum[W] != sum[W-1]) ? (sum[W] ? MINV : MAXV) : sum[W-1:0];
            end
            OP_SUB: begin
                n1_side = (diff[W] != diff[W-1]) ? (diff[W] ? MINV : MAXV) : diff[W-1:0];
            end
            OP_MUL: begin
                if ((&prod_sh[2*W-1:W-1]) || !(|prod_sh[2*W-1:W-1])) begin
                    n1_side = prod_sh[W-1:0];
                end else begin
                    n1_side = prod_sh[2*W-1] ? MINV : MAXV;
                end
            end
            OP_RELU: begin
                n1_side = r0_a[W-1] ? '0 : r0_a;
            end
            OP_CLAMP6: begin
                if (r0_a[W-1]) begin
                    n1_side = '0;
                end else if (r0_a > $signed(SIX)) begin
                    n1_side = SIX;
                end else begin
                    n1_side = r0_a;
                end
            end
            default: begin
                n1_side = r0_a;
            end
        endcase
        n1_ctl.valid  = r0_valid;
        n1_ctl.last   = r0_last;
        n1_ctl.is_div = (r0_op == OP_DIV);
        n1_ctl.neg    = r0_a[W-1] ^ r0_b[W-1];
        n1_ctl.zero   = (r0_b == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_ctl <= '0;
        end else begin
            r1_ctl <= n1_ctl;
        end
        r1_side <= n1_side;
        r1_den  <= n1_den;
        r1_word <= n1_word;
    end

    assign s_ctl[0]  = r1_ctl;
    assign s_side[0] = r1_side;
    assign s_den[0]  = r1_den;
    assign s_rem[0]  = '0;
    assign s_word[0] = r1_word;

    for (genvar g = 0; g < NB; g++) begin : g_cell
        sfva_div_cell #(
            .DATA_WIDTH (W),
            .WORD_BITS  (NB)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (s_ctl[g]),
            .i_side  (s_side[g]),
            .i_den   (s_den[g]),
            .i_rem   (s_rem[g]),
            .i_word  (s_word[g]),
            .o_ctl   (s_ctl[g+1]),
            .o_side  (s_side[g+1]),
            .o_den   (s_den[g+1]),
            .o_rem   (s_rem[g+1]),
            .o_word  (s_word[g+1])
        );
    end

    always_comb begin
        if (s_ctl[NB].neg) begin
            sq = ~({2'b00, s_word[NB]} + (NB+2)'(s_rem[NB] != '0)) + 1'b1;
        end else begin
            sq = {2'b00, s_word[NB]};
        end
        fits = (&sq[NB+1:W-1]) || !(|sq[NB+1:W-1]);
        if (s_ctl[NB].zero) begin
            div_res = '0;
        end else if (fits) begin
            div_res = sq[W-1:0];
        end else begin
            div_res = sq[NB+1] ? MINV : MAXV;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= s_ctl[NB].valid;
        end
        r_res  <= s_ctl[NB].is_div ? div_res : s_side[NB];
        r_last <= s_ctl[NB].last;
    end

    assign o_valid        = r_valid;
    assign o_result_value = r_res;
    assign o_last_out     = r_last;

endmodule

@@ sim/tb_saturating_fixed_point_vector_alu.sv @@
module tb_saturating_fixed_point_vector_alu;
    import sfva_pkg::*;

    localparam int DW = 16;
    localparam int IB = 8;
    localparam int FB = DW - IB;
    localparam int LATENCY = DW + FB + 2;
    localparam longint MAX_RAW = (64'sd1 <<< (DW - 1)) - 1;
    localparam longint MIN_RAW = -MAX_RAW - 1;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic signed [DW-1:0] value;
        logic                 last;
    } t_alu_out;

    class alu_scoreboard;
        t_alu_out pending[$];
        int       errors;

        function void note_item(t_alu_out e);
            pending.push_back(e);
        endfunction

        function void check_result(t_alu_out got);
            t_alu_out e;
            if (pending.size() == 0) begin
                report_mismatch("result with no item outstanding");
                return;
            end
            e = pending.pop_front();
            if (got.value !== e.value)
                report_mismatch($sformatf("value got %0d exp %0d", got.value, e.value));
            if (got.last !== e.last)
                report_mismatch($sformatf("last got %0b exp %0b", got.last, e.last));
        endfunction

        function void report_mismatch(string msg);
            $display("MISMATCH @%0t: %s", $realtime, msg);
            errors++;
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    logic signed [DW-1:0] i_a_value;
    logic signed [DW-1:0] i_b_value;
    logic                 i_last_in;
    logic                 o_valid;
    logic signed [DW-1:0] o_result_value;
    logic                 o_last_out;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [2:0]           i_cfg_data;

    alu_scoreboard sb;
    logic [2:0]    cur_op;
    int            idle_pct;
    longint        cycles;

    saturating_fixed_point_vector_alu #(.DATA_WIDTH(DW), .INT_BITS(IB)) u_dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic longint saturate(longint x);
        if (x > MAX_RAW) return MAX_RAW;
        if (x < MIN_RAW) return MIN_RAW;
        return x;
    endfunction

    function automatic logic signed [DW-1:0] alu_result(logic [2:0] op,
            logic signed [DW-1:0] a, logic signed [DW-1:0] b);
        longint la, lb, n, q, r, six;
        la = a;
        lb = b;
        six = 6 <<< FB;
        case (op)
            OP_ADD: return DW'(saturate(la + lb));
            OP_SUB: return DW'(saturate(la - lb));
            OP_MUL: return DW'(saturate((la * lb) >>> FB));
            OP_DIV: begin
                if (lb == 0) return '0;
                n = la <<< FB;
                q = n / lb;
                r = n % lb;
                if (r != 0 && ((r < 0) != (lb < 0))) q = q - 1;
                return DW'(saturate(q));
            end
            OP_RELU: return (la < 0) ? '0 : a;
            OP_CLAMP6: return (la < 0) ? '0 : ((la > six) ? DW'(six) : a);
            default: return a;
        endcase
    endfunction

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
        if (i_rst_n && o_valid)
            sb.check_result('{value: o_result_value, last: o_last_out});
    end

    task automatic send_item(logic signed [DW-1:0] a, logic signed [DW-1:0] b,
            logic last);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start     <= 1'b1;
        i_a_value <= a;
        i_b_value <= b;
        i_last_in <= last;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        sb.note_item('{value: alu_result(cur_op, a, b), last: last});
        @(negedge i_clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (LATENCY + 4) @(negedge i_clk);
    endtask

    task automatic write_op(logic [2:0] op);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= op;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        cur_op = op;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic signed [DW-1:0] pick_value();
        case ($urandom_range(5))
            0: return DW'(MAX_RAW - $urandom_range(3));
            1: return DW'(MIN_RAW + $urandom_range(3));
            2: return DW'(int'($urandom_range(7)) - 3);
            3: return DW'(int'($urandom_range(2047)) - 1024);
            default: return DW'($urandom);
        endcase
    endfunction

    initial begin
        logic signed [DW-1:0] edges[8];
        int phase_pct[4];
        sb = new();
        cycles = 0;
        cur_op = OP_ADD;
        idle_pct = 0;
        start = 1'b0;
        i_a_value = '0;
        i_b_value = '0;
        i_last_in = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        i_rst_n = 1'b0;
        edges = '{DW'(MAX_RAW), DW'(MIN_RAW), DW'(0), DW'(1), DW'(-1), DW'(6 << FB),
                  DW'((6 << FB) + 1), DW'(1 << FB)};
        phase_pct = '{0, 67, 0, 13};
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Reset operation is add; then sweep every code over the field extremes.
        for (int op = 0; op < 8; op++) begin
            if (op != 0) write_op(3'(op));
            for (int k = 0; k < 3; k++)
                send_item(edges[$urandom_range(7)], edges[(op + k) % 8], k[0]);
            send_item(edges[op], '0, 1'b1);
            drain();
        end

        for (int ph = 0; ph < 8; ph++) begin
            idle_pct = phase_pct[ph % 4];
            write_op((ph == 7) ? 3'd7 : 3'(ph));
            for (int n = 0; n < 175; n++)
                send_item(pick_value(), pick_value(), 1'($urandom));
            for (int n = 0; n < 200 && ph == 3; n++)
                send_item(pick_value(), DW'($urandom_range(255)) << FB, 1'($urandom));
            drain();
        end
        write_op(OP_ADD);

        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule

@@ saturating_fixed_point_vector_alu.f @@
sv/sfva_pkg.sv
sv/sfva_div_cell.sv
sv/saturating_fixed_point_vector_alu.sv
sim/tb_saturating_fixed_point_vector_alu.sv
